>>> rtl/core/upe_pkg.sv
package upe_pkg;

    // Fixed field widths of the stream items
    localparam int NUM_POS  = 8;
    localparam int VAL_W    = 5;
    localparam int LEN_W    = 4;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    // Request kinds carried on s_tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/unique_permutation_enumerator.sv
// Distinct permutation enumerator for a multiset of up to MAX_LEN values.
// Input stream (s_*): s_tuser is the request kind. A load request stores the
// length (saturated to MAX_LEN) and the values (saturated to the value range)
// and restarts the search; a next request asks for the next distinct
// permutation, in depth-first order with ascending index choice.
// Output stream (m_*): exactly one result per request. m_tuser is found; the
// elements are zero when found is low and at positions at or beyond length.
// A load, or a next request with nothing left to give, goes from idle straight
// to the emit state, which loads the output register. Any other next request
// first runs a depth-first search in the scan state, in which each cycle either
// tests one index at the current depth or pops one level.
// The block takes one request at a time: s_tready is high only while idle.
// While the receiver stalls, the output register holds its result; the block
// still takes one more request, works it out and holds that answer until the
// output register frees, with s_tready low meanwhile.
// Reset: nothing is loaded, so next requests answer found = 0 until a load.
module unique_permutation_enumerator
    import upe_pkg::*;
#(
    parameter int MAX_LEN    = 8,
    parameter int VALUE_SPAN = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // length[3:0], value_0 .. value_7 (5 bits each), zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // elem_0 .. elem_7 (5 bits each)
    output logic [M_DATA_W-1:0] m_tdata,
    // found
    output logic                m_tuser
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW     = $clog2(VALUE_SPAN);
    localparam int OFS    = (VALUE_SPAN - 1) / 2;
    localparam logic signed [6:0] VMIN = 7'(-OFS);
    localparam logic signed [6:0] VMAX = 7'(VALUE_SPAN - 1 - OFS);
    localparam logic signed [6:0] OFS7 = 7'(OFS);
    localparam logic [VALUE_SPAN-1:0] MARK_ONE = VALUE_SPAN'(1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [MAX_LEN-1:0]    used_reg, used_next;
    logic                  fresh_reg, fresh_next;
    logic                  started_reg, started_next;
    logic                  finished_reg, finished_next;
    logic                  found_reg, found_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [VAL_W-1:0]      val_reg [MAX_LEN];
    logic [VAL_W-1:0]      val_next [MAX_LEN];
    logic [IDX_W-1:0]      chosen_reg [MAX_LEN];
    logic [IDX_W-1:0]      chosen_next [MAX_LEN];
    logic [VALUE_SPAN-1:0] marks_reg [MAX_LEN];
    logic [VALUE_SPAN-1:0] marks_next [MAX_LEN];
    logic [VAL_W-1:0]      elem_reg [MAX_LEN];
    logic [VAL_W-1:0]      elem_next [MAX_LEN];

    logic                  s_accept;
    logic                  out_free;
    logic [LEN_W-1:0]      in_len;
    logic [CNT_W-1:0]      in_len_sat;
    logic [VAL_W-1:0]      in_val_sat [MAX_LEN];
    logic [MAX_LEN-1:0]    len_mask;

    logic                  in_range;
    logic [IDX_W-1:0]      sidx;
    logic [IDX_W-1:0]      didx;
    logic [IDX_W-1:0]      pidx;
    logic [VAL_W-1:0]      cur_val;
    logic signed [6:0]     cur_val7;
    logic signed [6:0]     cur_pos7;
    logic [VALUE_SPAN-1:0] cur_mark;
    logic [VALUE_SPAN-1:0] cur_marks;
    logic                  take;
    logic [IDX_W-1:0]      back_idx;
    logic [CNT_W-1:0]      depth_inc;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Saturate the load fields
    assign in_len = s_tdata[LEN_W-1:0];
    assign in_len_sat = (in_len > LEN_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : in_len[CNT_W-1:0];

    always_comb
    begin
        logic signed [6:0] v7;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            v7 = 7'(signed'(s_tdata[LEN_W + k*VAL_W +: VAL_W]));
            if (v7 < VMIN)
            begin
                in_val_sat[k] = VMIN[VAL_W-1:0];
            end
            else if (v7 > VMAX)
            begin
                in_val_sat[k] = VMAX[VAL_W-1:0];
            end
            else
            begin
                in_val_sat[k] = v7[VAL_W-1:0];
            end
        end
    end

    // Positions below the stored length
    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            len_mask[k] = (CNT_W'(k) < len_reg);
        end
    end

    // Shared test unit: one candidate index against used mask and tried values
    assign in_range  = (scan_reg < len_reg);
    assign sidx      = scan_reg[IDX_W-1:0];
    assign didx      = depth_reg[IDX_W-1:0];
    assign pidx      = IDX_W'(depth_reg - CNT_W'(1));
    assign cur_val   = val_reg[sidx];
    assign cur_val7  = 7'(signed'(cur_val));
    assign cur_pos7  = cur_val7 + OFS7;
    assign cur_mark  = MARK_ONE << cur_pos7[PW-1:0];
    assign cur_marks = fresh_reg ? '0 : marks_reg[didx];
    assign take      = in_range && !used_reg[sidx] && ((cur_marks & cur_mark) == '0);
    assign back_idx  = chosen_reg[pidx];
    assign depth_inc = depth_reg + CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == MODE_NEXT && !finished_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    if (depth_inc >= len_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (!in_range && depth_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        len_next      = len_reg;
        depth_next    = depth_reg;
        scan_next     = scan_reg;
        used_next     = used_reg;
        fresh_next    = fresh_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        found_next    = found_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        val_next      = val_reg;
        chosen_next   = chosen_reg;
        marks_next    = marks_reg;
        elem_next     = elem_reg;

        // Drop the output once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == MODE_LOAD)
                    begin
                        len_next      = in_len_sat;
                        val_next      = in_val_sat;
                        used_next     = '0;
                        depth_next    = '0;
                        started_next  = 1'b0;
                        finished_next = (in_len_sat == '0);
                        found_next    = 1'b0;
                    end
                    else if (finished_reg)
                    begin
                        found_next = 1'b0;
                    end
                    else if (!started_reg)
                    begin
                        // Start the search at the top level
                        started_next = 1'b1;
                        depth_next   = '0;
                        used_next    = '0;
                        scan_next    = '0;
                        fresh_next   = 1'b1;
                    end
                    else
                    begin
                        // Resume: an out-of-range scan at full depth pops the last level
                        depth_next = len_reg;
                        scan_next  = len_reg;
                        fresh_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    marks_next[didx]  = cur_marks | cur_mark;
                    chosen_next[didx] = sidx;
                    elem_next[didx]   = cur_val;
                    used_next[sidx]   = 1'b1;
                    depth_next        = depth_inc;
                    if (depth_inc >= len_reg)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        scan_next  = '0;
                        fresh_next = 1'b1;
                    end
                end
                else if (in_range)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                else if (depth_reg == '0)
                begin
                    finished_next = 1'b1;
                    found_next    = 1'b0;
                end
                else
                begin
                    // Backtrack one level and continue after its chosen index
                    depth_next       = depth_reg - CNT_W'(1);
                    used_next[back_idx] = 1'b0;
                    scan_next        = CNT_W'(back_idx) + CNT_W'(1);
                    fresh_next       = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = found_reg;
                    m_tdata_next  = '0;
                    for (int k = 0; k < MAX_LEN; k++)
                    begin
                        if (found_reg && len_mask[k])
                        begin
                            m_tdata_next[k*VAL_W +: VAL_W] = elem_reg[k];
                        end
                    end
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            depth_reg    <= '0;
            scan_reg     <= '0;
            used_reg     <= '0;
            fresh_reg    <= 1'b0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b1;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            depth_reg    <= depth_next;
            scan_reg     <= scan_next;
            used_reg     <= used_next;
            fresh_reg    <= fresh_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
        val_reg     <= val_next;
        chosen_reg  <= chosen_next;
        marks_reg   <= marks_next;
        elem_reg    <= elem_next;
    end

`ifndef ASSERT_OFF
    // Each chosen level holds exactly one index in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ($countones(used_reg) == int'(depth_reg)))
        else $error("used mask does not match search depth");

    // The search never goes deeper than the stored length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (depth_reg <= len_reg))
        else $error("search depth beyond stored length");

    // A found permutation uses every stored index
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && found_reg) |-> (used_reg == len_mask))
        else $error("found result with incomplete index set");

    // A stalled result keeps the sequencer waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("result left the emit state while output stalled");

    // A zero-length load finishes the search at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == MODE_LOAD && s_tdata[LEN_W-1:0] == '0) |=> finished_reg)
        else $error("zero-length load did not finish the search");
`endif

endmodule
